// File: hw/rtl/spq_pkg.sv
// Shared types, widths and codes for the stable priority ready queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  localparam int IN_BITS      = OP_BITS + ID_BITS + PRIO_BITS;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = STATUS_BITS + ID_BITS + PRIO_BITS + CNT_BITS;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;

  localparam logic [OP_BITS-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RMH  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_FIND = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                 insert;
    logic                 pop;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// One slot of the sorted register chain: holds an entry, shifts on insert or pop.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occ,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  logic      found_in,
  input  entry_t    found_entry_in,
  output entry_t    entry,
  output logic      keep,
  output logic      found_out,
  output entry_t    found_entry_out
);

  logic hit;

  // An occupied slot whose priority is not larger than the new one stays put.
  assign keep = occ && (entry.prio <= cmd.prio);
  // Only the first matching slot from the head reports itself.
  assign hit = occ && (entry.id == cmd.id) && !found_in;
  assign found_out = found_in || hit;
  assign found_entry_out = hit ? entry : found_entry_in;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!keep) begin
        if (left_keep) begin
          entry <= '{prio: cmd.prio, id: cmd.id};
        end else begin
          entry <= left_entry;
        end
      end
    end else if (cmd.pop) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stable_priority_ready_queue.sv
// Top level of the stable priority ready queue: cell chain, count and result register.
// Depends on spq_pkg and spq_cell.
//
// Usage: operations arrive on the s_* stream and each produces exactly one
// result transfer on the m_* stream. An operation is enqueue, dequeue head,
// remove head if its id matches, or find an id. Lower priority numbers are
// served first and equal priorities leave in arrival order.
// Each slot of the queue is a cell in a row; on enqueue every cell past the
// insertion point takes its left neighbor's entry, on a pop every cell takes
// its right neighbor's entry, and a find ripples a match flag down the row.
// The result is registered at the edge that accepts the operation and shown
// on m_tvalid in the next cycle. Throughput is one operation per cycle while
// the receiver takes each result, as the whole cell row updates at that edge.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; a new operation is taken in the same
// cycle that the waiting result is taken.
// Reset empties the queue and clears the pending result; slot contents are
// left as they are, since only slots below the count are ever read.
`default_nettype none

module stable_priority_ready_queue import spq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // op [1:0], thread_id [9:2], prio [17:10], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status [1:0], out_id [9:2], out_prio [17:10], entry_count [22:18], zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [OP_BITS-1:0]     in_op;
  logic [ID_BITS-1:0]     in_id;
  logic [PRIO_BITS-1:0]   in_prio;
  logic                   accept;

  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    count_next;
  logic                   full;
  logic                   empty;

  logic [STATUS_BITS-1:0] status;
  logic [STATUS_BITS-1:0] status_next;
  logic [ID_BITS-1:0]     out_id;
  logic [ID_BITS-1:0]     out_id_next;
  logic [PRIO_BITS-1:0]   out_prio;
  logic [PRIO_BITS-1:0]   out_prio_next;
  logic [CNT_BITS-1:0]    entry_count;

  cell_cmd_t              cmd;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic                   cell_keep  [QUEUE_DEPTH];
  logic                   found      [QUEUE_DEPTH+1];
  entry_t                 found_entry[QUEUE_DEPTH+1];

  assign in_op   = s_tdata[OP_BITS-1:0];
  assign in_id   = s_tdata[OP_BITS +: ID_BITS];
  assign in_prio = s_tdata[OP_BITS+ID_BITS +: PRIO_BITS];

  // The output register frees up in the same cycle its result is taken.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // The search chain starts empty at the head.
  assign found[0]       = 1'b0;
  assign found_entry[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (CNT_BITS'(i) < count);

    if (i == 0) begin : g_head
      // The head always takes the new entry unless it stays put.
      assign left_keep  = 1'b1;
      assign left_entry = '{prio: in_prio, id: in_id};
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk             (clk),
      .cmd             (cmd),
      .occ             (occ),
      .left_keep       (left_keep),
      .left_entry      (left_entry),
      .right_entry     (right_entry),
      .found_in        (found[i]),
      .found_entry_in  (found_entry[i]),
      .entry           (cell_entry[i]),
      .keep            (cell_keep[i]),
      .found_out       (found[i+1]),
      .found_entry_out (found_entry[i+1])
    );
  end

  // Decode the operation into a status, a reported entry and the new count.
  always_comb begin
    status_next   = ST_OK;
    out_id_next   = '0;
    out_prio_next = '0;
    count_next    = count;
    case (in_op)
      OP_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_BITS'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          out_id_next   = cell_entry[0].id;
          out_prio_next = cell_entry[0].prio;
          count_next    = count - CNT_BITS'(1);
        end
      end
      OP_RMH: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (cell_entry[0].id == in_id) begin
          out_id_next   = cell_entry[0].id;
          out_prio_next = cell_entry[0].prio;
          count_next    = count - CNT_BITS'(1);
        end else begin
          status_next = ST_MISS;
        end
      end
      OP_FIND: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (found[QUEUE_DEPTH]) begin
          out_id_next   = found_entry[QUEUE_DEPTH].id;
          out_prio_next = found_entry[QUEUE_DEPTH].prio;
        end else begin
          status_next = ST_MISS;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  always_comb begin
    cmd.id     = in_id;
    cmd.prio   = in_prio;
    cmd.insert = accept && (in_op == OP_ENQ) && !full;
    cmd.pop    = accept && (status_next == ST_OK) &&
                 ((in_op == OP_DEQ) || (in_op == OP_RMH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      out_id      <= out_id_next;
      out_prio    <= out_prio_next;
      entry_count <= count_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, entry_count, out_prio, out_id, status};

`ifndef SYNTH
  // The reported count always matches the live occupancy after the transfer.
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (entry_count == count))
    else $error("reported entry count differs from occupancy");

  // A full report only comes from a queue holding every slot.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == ST_FULL)) |-> (entry_count == CNT_BITS'(QUEUE_DEPTH)))
    else $error("full status with a queue that is not full");

  // Empty and miss reports never carry an entry.
  a_no_data_on_fail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((status == ST_EMPTY) || (status == ST_MISS))) |->
      ((out_id == '0) && (out_prio == '0)))
    else $error("failed operation reports an entry");

  // A stalled result blocks new operations.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("operation accepted while a result is stalled");

  // The count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (count <= CNT_BITS'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");
`endif

endmodule

`default_nettype wire

// File: dv/stable_priority_ready_queue_test.sv
// Self-checking testbench for the stable priority ready queue: directed and random
// operations with random stalls on both stream sides, checked against a queue model.
// Depends on spq_pkg and the stable_priority_ready_queue RTL.
`default_nettype none

module stable_priority_ready_queue_test;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     id;
    logic [PRIO_BITS-1:0]   prio;
    logic [CNT_BITS-1:0]    count;
  } op_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Entries in service order, head first, as the queue should hold them.
  entry_t     queued_entries[$];
  // Results owed by the block, oldest first.
  op_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  stable_priority_ready_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the queue model and returns the result it owes.
  function automatic op_result_t apply_queue_op(logic [OP_BITS-1:0] op,
                                                logic [ID_BITS-1:0] id,
                                                logic [PRIO_BITS-1:0] pr);
    op_result_t r;
    entry_t     e;
    int         pos;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ENQ) begin
      if (queued_entries.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Insert ahead of the first strictly larger number, so ties stay FIFO.
        pos = 0;
        while (pos < queued_entries.size() && !(pr < queued_entries[pos].prio)) pos++;
        e.id = id;
        e.prio = pr;
        queued_entries.insert(pos, e);
      end
    end else if (queued_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_DEQ) begin
      r.id = queued_entries[0].id;
      r.prio = queued_entries[0].prio;
      void'(queued_entries.pop_front());
    end else if (op == OP_RMH) begin
      if (queued_entries[0].id == id) begin
        r.id = queued_entries[0].id;
        r.prio = queued_entries[0].prio;
        void'(queued_entries.pop_front());
      end else begin
        r.status = ST_MISS;
      end
    end else begin
      r.status = ST_MISS;
      foreach (queued_entries[i]) begin
        if (r.status == ST_MISS && queued_entries[i].id == id) begin
          r.status = ST_OK;
          r.id = queued_entries[i].id;
          r.prio = queued_entries[i].prio;
        end
      end
    end
    r.count = CNT_BITS'(queued_entries.size());
    return r;
  endfunction

  // Offers one operation, with random gaps first, and records what it owes once
  // the transfer happens. The valid stays high afterward so that back-to-back
  // operations never lower and raise it within one time step.
  task automatic send_op(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                         input logic [PRIO_BITS-1:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'({pr, id, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, id, pr));
  endtask

  // Holds off the sender until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Every non-enqueue operation on an empty queue, with ids at both extremes.
  task automatic test_empty_queue();
    send_op(OP_DEQ, 8'h00, 8'hFF);
    send_op(OP_RMH, 8'hFF, 8'h00);
    send_op(OP_FIND, 8'h00, 8'h00);
  endtask

  // Fills the queue with heavy priority ties and repeated ids, then overfills it.
  task automatic test_sorted_fill();
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] pr;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id = (i == QUEUE_DEPTH - 1) ? 8'hFF : ID_BITS'(i % 12);
      pr = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h80;
      send_op(OP_ENQ, id, pr);
    end
    send_op(OP_ENQ, 8'hAA, 8'h00);
  endtask

  // Find hits a queued id and misses an absent one; remove-if-head
  // misses on the tail id and hits on the actual head id.
  task automatic test_find_and_remove();
    send_op(OP_FIND, 8'h03, 8'h00);
    send_op(OP_FIND, 8'h77, 8'h00);
    send_op(OP_RMH, 8'hFF, 8'h00);
    send_op(OP_RMH, 8'h01, 8'h00);
    send_op(OP_DEQ, 8'h00, 8'h00);
  endtask

  // Random traffic that swings the queue between empty and full. Ids and
  // priorities are often drawn from narrow ranges so that ties and repeated ids
  // are common, and remove-if-head and find mostly aim at queued ids.
  task automatic test_random_traffic(input int n_ops);
    logic                 filling;
    logic [OP_BITS-1:0]   op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] pr;
    int                   pick;
    filling = 1'($urandom_range(1));
    for (int k = 0; k < n_ops; k++) begin
      if (queued_entries.size() == QUEUE_DEPTH) filling = 1'b0;
      else if (queued_entries.size() == 0) filling = 1'b1;
      else if ($urandom_range(31) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (filling) begin
        op = (pick < 65) ? OP_ENQ : (pick < 75) ? OP_DEQ : (pick < 88) ? OP_RMH : OP_FIND;
      end else begin
        op = (pick < 25) ? OP_ENQ : (pick < 55) ? OP_DEQ : (pick < 80) ? OP_RMH : OP_FIND;
      end
      id = $urandom_range(1) ? ID_BITS'($urandom_range(15)) : ID_BITS'($urandom_range(255));
      pr = $urandom_range(1) ? PRIO_BITS'($urandom_range(7)) : PRIO_BITS'($urandom_range(255));
      if (queued_entries.size() != 0) begin
        if (op == OP_RMH && $urandom_range(99) < 70) begin
          id = queued_entries[0].id;
        end else if (op == OP_FIND && $urandom_range(99) < 60) begin
          id = queued_entries[$urandom_range(queued_entries.size() - 1)].id;
        end
      end
      send_op(op, id, pr);
      if (k % 200 == 199) wait_drained();
    end
  endtask

  // Receiver side: random stalls, and a field-by-field check of each transfer.
  always @(posedge clk) begin
    op_result_t exp_r;
    op_result_t got_r;
    if (!rst && m_tvalid && m_tready) begin
      got_r.status = m_tdata[STATUS_BITS-1:0];
      got_r.id = m_tdata[STATUS_BITS +: ID_BITS];
      got_r.prio = m_tdata[STATUS_BITS + ID_BITS +: PRIO_BITS];
      got_r.count = m_tdata[STATUS_BITS + ID_BITS + PRIO_BITS +: CNT_BITS];
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing owed: tdata %h", m_tdata);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
          error_count++;
        end
        if (got_r.id !== exp_r.id) begin
          $error("out_id: expected %0d, got %0d", exp_r.id, got_r.id);
          error_count++;
        end
        if (got_r.prio !== exp_r.prio) begin
          $error("out_prio: expected %0d, got %0d", exp_r.prio, got_r.prio);
          error_count++;
        end
        if (got_r.count !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, got_r.count);
          error_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    recv_idle_pct = 56;
    test_empty_queue();
    test_sorted_fill();
    test_find_and_remove();
    test_random_traffic(560);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 27;
    test_random_traffic(560);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);
    wait_drained();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
